[hdl/esc_pkg.sv]
//------------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block
//------------------------------------------------------------------------------
`default_nettype none
package esc_pkg;

	localparam logic [19:0] SKIP_TP = 20'h80000;
	localparam logic [15:0] SKIP_H  = 16'h8000;
	localparam logic [31:0] HUM_MAX = 32'd419430400;

	localparam logic [2:0] REG_TEMP   = 3'd0;
	localparam logic [2:0] REG_PLOW   = 3'd1;
	localparam logic [2:0] REG_PHIGH  = 3'd2;
	localparam logic [2:0] REG_PNINE  = 3'd3;
	localparam logic [2:0] REG_HBYTES = 3'd4;
	localparam logic [2:0] REG_HWIDE  = 3'd5;

	// datapath operations, one per controller step
	typedef enum logic [5:0] {
		OP_NOP,
		OP_LOAD,
		OP_T_A,      // a = (t>>3) - (t1<<1); m = a*t2
		OP_T_B,      // v1 = asr(m,11); b = (t>>4)-t1; m = b*b
		OP_T_C,      // m = asr(m,12)*t3
		OP_T_D,      // fine = v1 + asr(m,14); m = fine*5
		OP_T_E,      // tc = asr(m+128,8)
		OP_P_A,      // v1 = asr(fine,1)-64000; q = asr(v1,2); m = q*q
		OP_P_B,      // s = m; m = asr(m,11)*p6
		OP_P_C,      // v2 = m; m = v1*p5
		OP_P_D,      // v2 = asr(v2+(m<<1),2)+(p4<<16); m = p3*asr(s,13)
		OP_P_E,      // w = asr(m,3); m = p2*v1
		OP_P_F,      // v1 = asr(w+asr(m,1),18); m = (32768+v1)*p1
		OP_P_G,      // v1 = asr(m,15); m = ((1048576-adc)-asr(v2,12))*3125
		OP_P_H,      // p = m, start division
		OP_P_I,      // p = quotient adjust; m = (p>>3)*(p>>3)
		OP_P_J,      // m = p9*(m>>13)
		OP_P_K,      // w = asr(m,12); m = (p>>2)*p8
		OP_P_L,      // pc = p + asr(w+asr(m,13)+p7,4)
		OP_H_A,      // x = fine-76800; m = h5*x
		OP_H_B,      // a = asr((h<<14)-(h4<<20)-m+16384,15); m = x*h6
		OP_H_C,      // w = asr(m,10); m = x*h3
		OP_H_D,      // m = w*(asr(m,11)+32768)
		OP_H_E,      // b = asr(m,10)+2097152; m = b*h2
		OP_H_F,      // b = asr(m+8192,14); m = a*b
		OP_H_G,      // x = m; w = asr(m,15); m = w*w
		OP_H_H,      // m = asr(m,7)*h1
		OP_H_I       // hc = clamp(x - asr(m,4)) >> 12
	} op_t;

	typedef struct packed {
		op_t  op;
		logic t_ok;    // temperature not skipped
		logic div_go;
	} esc_cmd_t;

	typedef struct packed {
		logic p_skip;
		logic h_skip;
		logic t_skip;
		logic div_zero;
		logic div_busy;
	} esc_stat_t;

endpackage
`default_nettype wire

[hdl/esc_div.sv]
//------------------------------------------------------------------------------
// esc_div
// Restoring unsigned 32 by 32 divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`default_nettype none
module esc_div import esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	property p_done_after_run;
		@(posedge clk) disable iff (!arst_n) start |=> busy;
	endproperty
	a_done_after_run: assert property (p_done_after_run) else $error("divider not busy");

	property p_count_down;
		@(posedge clk) disable iff (!arst_n) (busy && !start) |=> cnt_q == $past(cnt_q) - 6'd1;
	endproperty
	a_count_down: assert property (p_count_down) else $error("divider count slip");

	property p_idle_hold;
		@(posedge clk) disable iff (!arst_n) (!busy && !start) |=> $stable(quo_q);
	endproperty
	a_idle_hold: assert property (p_idle_hold) else $error("quotient moved while idle");
endmodule
`default_nettype wire

[hdl/esc_datapath.sv]
//------------------------------------------------------------------------------
// esc_datapath
// Coefficient registers, shared 32x32 multiplier, divider and work registers
//------------------------------------------------------------------------------
`default_nettype none
module esc_datapath import esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic [19:0] in_temp,
	input  wire logic [19:0] in_press,
	input  wire logic [15:0] in_hum,
	input  wire esc_cmd_t    cmd,
	output esc_stat_t        stat,
	output logic [31:0]      temp_centi,
	output logic [31:0]      press_pa,
	output logic [16:0]      hum_q10
);
	logic [47:0] tc_q;
	logic [63:0] pl_q, ph_q;
	logic [15:0] p9_q;
	logic [39:0] hb_q;
	logic [31:0] hw_q;
	logic [31:0] fine_q;
	logic [19:0] t_q, p_q;
	logic [15:0] h_q;
	logic [31:0] m_q, v1_q, v2_q, s_q, w_q, x_q, a_q, pv_q;
	logic [31:0] tcen_q, pres_q;
	logic [16:0] hum_q;

	logic [31:0] ma, mb, mul;
	logic [31:0] r0, r1, r2, q_w;
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic        div_busy;
	logic [31:0] quo;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	assign t1 = {16'd0, tc_q[15:0]};
	assign t2 = sx16(tc_q[31:16]);
	assign t3 = sx16(tc_q[47:32]);
	assign p1 = {16'd0, pl_q[15:0]};
	assign p2 = sx16(pl_q[31:16]);
	assign p3 = sx16(pl_q[47:32]);
	assign p4 = sx16(pl_q[63:48]);
	assign p5 = sx16(ph_q[15:0]);
	assign p6 = sx16(ph_q[31:16]);
	assign p7 = sx16(ph_q[47:32]);
	assign p8 = sx16(ph_q[63:48]);
	assign p9 = sx16(p9_q);
	assign h1 = {24'd0, hb_q[7:0]};
	assign h2 = sx16(hb_q[23:8]);
	assign h3 = {24'd0, hb_q[31:24]};
	assign h6 = {{24{hb_q[39]}}, hb_q[39:32]};
	assign h4 = sx16(hw_q[15:0]);
	assign h5 = sx16(hw_q[31:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pl_q <= '0;
			ph_q <= '0;
			p9_q <= '0;
			hb_q <= '0;
			hw_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP:   tc_q <= cfg_data[47:0];
				REG_PLOW:   pl_q <= cfg_data;
				REG_PHIGH:  ph_q <= cfg_data;
				REG_PNINE:  p9_q <= cfg_data[15:0];
				REG_HBYTES: hb_q <= cfg_data[39:0];
				REG_HWIDE:  hw_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier, low 32 bits kept
	always_comb begin
		ma = '0;
		mb = '0;
		r0 = '0;
		r1 = '0;
		r2 = '0;
		q_w = asr(asr(fine_q, 1) - 32'd64000, 2);
		case (cmd.op)
			OP_T_A: begin
				ma = {12'd0, t_q} >> 3;
				ma = ma - (t1 << 1);
				mb = t2;
			end
			OP_T_B: begin
				ma = ({12'd0, t_q} >> 4) - t1;
				mb = ma;
			end
			OP_T_C: begin ma = asr(m_q, 12); mb = t3; end
			OP_T_D: begin
				r0 = v1_q + asr(m_q, 14);
				ma = r0;
				mb = 32'd5;
			end
			OP_P_A: begin ma = q_w; mb = q_w; end
			OP_P_B: begin ma = asr(m_q, 11); mb = p6; end
			OP_P_C: begin ma = v1_q; mb = p5; end
			OP_P_D: begin ma = p3; mb = asr(s_q, 13); end
			OP_P_E: begin ma = p2; mb = v1_q; end
			OP_P_F: begin
				r0 = asr(w_q + asr(m_q, 1), 18);
				ma = 32'd32768 + r0;
				mb = p1;
			end
			OP_P_G: begin
				ma = (32'd1048576 - {12'd0, p_q}) - asr(v2_q, 12);
				mb = 32'd3125;
			end
			OP_P_I: begin
				r1 = pv_q[31] ? {quo[30:0], 1'b0} : quo;
				ma = r1 >> 3;
				mb = ma;
			end
			OP_P_J: begin ma = p9; mb = m_q >> 13; end
			OP_P_K: begin ma = pv_q >> 2; mb = p8; end
			OP_H_A: begin ma = h5; mb = fine_q - 32'd76800; end
			OP_H_B: begin ma = x_q; mb = h6; end
			OP_H_C: begin ma = x_q; mb = h3; end
			OP_H_D: begin ma = w_q; mb = asr(m_q, 11) + 32'd32768; end
			OP_H_E: begin ma = asr(m_q, 10) + 32'd2097152; mb = h2; end
			OP_H_F: begin ma = a_q; mb = asr(m_q + 32'd8192, 14); end
			OP_H_G: begin ma = asr(m_q, 15); mb = ma; end
			OP_H_H: begin ma = asr(m_q, 7); mb = h1; end
			OP_H_I: begin
				r2 = x_q - asr(m_q, 4);
			end
			default: ;
		endcase
	end

	assign mul = 32'(ma * mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (cmd.op == OP_T_D && cmd.t_ok) begin
			fine_q <= r0;
		end
	end

	always_ff @(posedge clk) begin
		m_q <= mul;
		case (cmd.op)
			OP_LOAD: begin
				t_q <= in_temp;
				p_q <= in_press;
				h_q <= in_hum;
				tcen_q <= '0;
				pres_q <= '0;
				hum_q <= '0;
			end
			OP_T_B: v1_q <= asr(m_q, 11);
			OP_T_E: if (cmd.t_ok) tcen_q <= asr(m_q + 32'd128, 8);
			OP_P_A: v1_q <= asr(fine_q, 1) - 32'd64000;
			OP_P_B: s_q <= m_q;
			OP_P_C: v2_q <= m_q;
			OP_P_D: v2_q <= asr(v2_q + (m_q << 1), 2) + (p4 << 16);
			OP_P_E: w_q <= asr(m_q, 3);
			OP_P_G: v1_q <= asr(m_q, 15);
			OP_P_H: pv_q <= m_q;
			OP_P_I: pv_q <= r1;
			OP_P_K: w_q <= asr(m_q, 12);
			OP_P_L: pres_q <= pv_q + asr(w_q + asr(m_q, 13) + p7, 4);
			OP_H_A: x_q <= fine_q - 32'd76800;
			OP_H_B: a_q <= asr(({16'd0, h_q} << 14) - (h4 << 20) - m_q + 32'd16384, 15);
			OP_H_C: w_q <= asr(m_q, 10);
			OP_H_G: x_q <= m_q;
			OP_H_I: begin
				if (r2[31]) hum_q <= '0;
				else if (r2 > HUM_MAX) hum_q <= HUM_MAX[28:12];
				else hum_q <= r2[28:12];
			end
			default: ;
		endcase
	end

	// dividend: p<2^31 gives (p<<1)/v1, else p/v1 then doubled
	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (m_q[31] ? m_q : {m_q[30:0], 1'b0}),
		.divisor  (v1_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign stat.t_skip   = (t_q == SKIP_TP);
	assign stat.p_skip   = (p_q == SKIP_TP);
	assign stat.h_skip   = (h_q == SKIP_H);
	assign stat.div_zero = (v1_q == '0);
	assign stat.div_busy = div_busy;

	assign temp_centi = tcen_q;
	assign press_pa   = pres_q;
	assign hum_q10    = hum_q;

	property p_fine_hold;
		@(posedge clk) disable iff (!arst_n) (cmd.op != OP_T_D) |=> $stable(fine_q);
	endproperty
	a_fine_hold: assert property (p_fine_hold) else $error("fine temperature moved");

	property p_hum_range;
		@(posedge clk) disable iff (!arst_n) $past(cmd.op) == OP_H_I |-> hum_q <= 17'd102400;
	endproperty
	a_hum_range: assert property (p_hum_range) else $error("humidity out of range");

	property p_div_nonzero;
		@(posedge clk) disable iff (!arst_n) cmd.div_go |-> !stat.div_zero;
	endproperty
	a_div_nonzero: assert property (p_div_nonzero) else $error("divide by zero");
endmodule
`default_nettype wire

[hdl/esc_ctrl.sv]
//------------------------------------------------------------------------------
// esc_ctrl
// Sequencer stepping the datapath through the compensation and the handshake
//------------------------------------------------------------------------------
`default_nettype none
module esc_ctrl import esc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire esc_stat_t stat,
	output esc_cmd_t       cmd
);
	typedef enum logic [1:0] {IDLE, RUN, DIVW, DONE} state_t;

	state_t state_q;
	op_t    op_q;
	logic   t_ok;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = (state_q == DONE);
	assign t_ok      = !stat.t_skip;

	always_comb begin
		cmd.op     = OP_NOP;
		cmd.t_ok   = t_ok;
		cmd.div_go = 1'b0;
		if (state_q == IDLE && in_valid) cmd.op = OP_LOAD;
		else if (state_q == RUN) cmd.op = op_q;
		else if (state_q == DIVW && !stat.div_busy) cmd.op = OP_P_I;
		if (state_q == RUN && op_q == OP_P_H && !stat.div_zero) cmd.div_go = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			op_q    <= OP_NOP;
		end else begin
			case (state_q)
				IDLE: if (in_valid) begin
					state_q <= RUN;
					op_q    <= OP_T_A;
				end
				RUN: begin
					case (op_q)
						OP_T_E: op_q <= stat.p_skip ? OP_H_A : OP_P_A;
						OP_P_G: ;
						OP_P_H: state_q <= DIVW;
						OP_P_L: op_q <= OP_H_A;
						OP_H_I: state_q <= DONE;
						default: op_q <= op_t'(op_q + 6'd1);
					endcase
					// a zero divisor leaves pressure at zero
					if (op_q == OP_P_G) begin
						op_q <= OP_P_H;
					end
					if (op_q == OP_P_H && stat.div_zero) begin
						state_q <= RUN;
						op_q    <= OP_H_A;
					end
					if ((op_q == OP_T_E && stat.p_skip) || (op_q == OP_P_L)
						|| (op_q == OP_P_H && stat.div_zero)) begin
						if (stat.h_skip) state_q <= DONE;
					end
				end
				DIVW: if (!stat.div_busy) begin
					state_q <= RUN;
					op_q    <= OP_P_J;
				end
				DONE: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	property p_no_take_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != IDLE) |-> !in_ready;
	endproperty
	a_no_take_busy: assert property (p_no_take_busy) else $error("input taken while busy");

	property p_result_holds;
		@(posedge clk) disable iff (!arst_n) (out_valid && !out_ready) |=> out_valid;
	endproperty
	a_result_holds: assert property (p_result_holds) else $error("result dropped");

	property p_accept_starts;
		@(posedge clk) disable iff (!arst_n) (in_valid && in_ready) |=> state_q == RUN;
	endproperty
	a_accept_starts: assert property (p_accept_starts) else $error("accept did not start");
endmodule
`default_nettype wire

[hdl/env_sensor_compensation.sv]
//------------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings
//------------------------------------------------------------------------------
// One input beat is taken at a time and one result beat is produced for it.
// All steps share one 32x32 multiplier, one product per cycle, and pressure
// uses a restoring divider; m_tvalid rises latest for a full set and sooner when
// pressure is skipped, on a zero pressure divisor or when humidity is skipped.
// The next beat can be taken in the cycle after the result beat has been delivered.
// Coefficients are to be written through cfg_we only while idle; the block itself
// does not enforce this.
`default_nettype none
module env_sensor_compensation import esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata   // temp_centi[31:0], press_pa[63:32], hum_q10[80:64]
);
	esc_cmd_t    cmd;
	esc_stat_t   stat;
	logic [31:0] temp_centi, press_pa;
	logic [16:0] hum_q10;

	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	esc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_temp    (s_tdata[19:0]),
		.in_press   (s_tdata[39:20]),
		.in_hum     (s_tdata[55:40]),
		.cmd        (cmd),
		.stat       (stat),
		.temp_centi (temp_centi),
		.press_pa   (press_pa),
		.hum_q10    (hum_q10)
	);

	assign m_tdata = {7'd0, hum_q10, press_pa, temp_centi};
endmodule
`default_nettype wire

[verif/env_sensor_compensation_tb.sv]
//------------------------------------------------------------------------------
// env_sensor_compensation_tb
// Self-checking bench for the integer temperature / pressure / humidity block
//------------------------------------------------------------------------------
// Readings are sent over the input stream. A cycle-free predictor computes the
// compensated values when a reading is accepted and keeps its own fine
// temperature and coefficients. Each result beat is checked field by field
// against the oldest prediction. Coefficients are rewritten only while idle,
// with fixed, extreme and random sets, under several idle/stall mixes.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_tb;
	import esc_pkg::*;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1000;

	typedef struct packed {
		logic [16:0] hum_q10;
		logic [31:0] press_pa;
		logic [31:0] temp_centi;
	} comp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;

	env_sensor_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [47:0] coef_t;
	logic [63:0] coef_pl, coef_ph;
	logic [15:0] coef_p9;
	logic [39:0] coef_hb;
	logic [31:0] coef_hw;
	logic [31:0] fine_t;

	comp_result_t expected_q[$];
	bit           failed = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           quiet_cycles = 0;

	function automatic logic [31:0] asr(logic [31:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] temp_comp(logic [31:0] t);
		logic [31:0] t1, t2, t3, a, v1, b, m;
		t1 = {16'd0, coef_t[15:0]};
		t2 = sx16(coef_t[31:16]);
		t3 = sx16(coef_t[47:32]);
		a  = (t >> 3) - (t1 << 1);
		m  = a * t2;
		v1 = asr(m, 11);
		b  = (t >> 4) - t1;
		m  = b * b;
		m  = asr(m, 12) * t3;
		fine_t = v1 + asr(m, 14);
		m  = fine_t * 32'd5 + 32'd128;
		return asr(m, 8);
	endfunction

	function automatic logic [31:0] press_comp(logic [31:0] adc);
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] v1, v2, q, qq, m, p, w1, w2;
		p1 = {16'd0, coef_pl[15:0]};
		p2 = sx16(coef_pl[31:16]);
		p3 = sx16(coef_pl[47:32]);
		p4 = sx16(coef_pl[63:48]);
		p5 = sx16(coef_ph[15:0]);
		p6 = sx16(coef_ph[31:16]);
		p7 = sx16(coef_ph[47:32]);
		p8 = sx16(coef_ph[63:48]);
		p9 = sx16(coef_p9);
		v1 = asr(fine_t, 1) - 32'd64000;
		q  = asr(v1, 2);
		qq = q * q;
		v2 = asr(qq, 11) * p6;
		m  = v1 * p5;
		v2 = v2 + (m << 1);
		v2 = asr(v2, 2) + (p4 << 16);
		m  = p3 * asr(qq, 13);
		w1 = p2 * v1;
		v1 = asr(asr(m, 3) + asr(w1, 1), 18);
		m  = (32'd32768 + v1) * p1;
		v1 = asr(m, 15);
		if (v1 == 32'd0)
			return 32'd0;
		p = ((32'd1048576 - adc) - asr(v2, 12)) * 32'd3125;
		if (p < 32'h80000000)
			p = (p << 1) / v1;
		else
			p = (p / v1) * 32'd2;
		m  = (p >> 3) * (p >> 3);
		m  = p9 * (m >> 13);
		w1 = asr(m, 12);
		m  = (p >> 2) * p8;
		w2 = asr(m, 13);
		return p + asr(w1 + w2 + p7, 4);
	endfunction

	function automatic logic [31:0] hum_comp(logic [31:0] h);
		logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, m, w;
		h1 = {24'd0, coef_hb[7:0]};
		h2 = sx16(coef_hb[23:8]);
		h3 = {24'd0, coef_hb[31:24]};
		h6 = {{24{coef_hb[39]}}, coef_hb[39:32]};
		h4 = sx16(coef_hw[15:0]);
		h5 = sx16(coef_hw[31:16]);
		x  = fine_t - 32'd76800;
		m  = h5 * x;
		a  = asr((h << 14) - (h4 << 20) - m + 32'd16384, 15);
		m  = x * h6;
		w  = asr(m, 10);
		m  = x * h3;
		b  = w * (asr(m, 11) + 32'd32768);
		b  = asr(b, 10) + 32'd2097152;
		m  = b * h2 + 32'd8192;
		b  = asr(m, 14);
		x  = a * b;
		w  = asr(x, 15);
		m  = w * w;
		m  = asr(m, 7) * h1;
		x  = x - asr(m, 4);
		if (x[31])
			x = 32'd0;
		if (x > HUM_MAX)
			x = HUM_MAX;
		return x >> 12;
	endfunction

	function automatic comp_result_t compensate(logic [55:0] beat);
		comp_result_t r;
		r = '0;
		if (beat[19:0] != SKIP_TP)
			r.temp_centi = temp_comp({12'd0, beat[19:0]});
		if (beat[39:20] != SKIP_TP)
			r.press_pa = press_comp({12'd0, beat[39:20]});
		if (beat[55:40] != SKIP_H)
			r.hum_q10 = 17'(hum_comp({16'd0, beat[55:40]}));
		return r;
	endfunction

	// receiver stalls and result checking
	always @(posedge clk) begin
		comp_result_t got, exp_r;
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (m_tvalid && m_tready) begin
			got = m_tdata[80:0];
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				failed = 1;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.temp_centi !== exp_r.temp_centi) begin
					$error("temp_centi expected %0d got %0d",
						$signed(exp_r.temp_centi), $signed(got.temp_centi));
					failed = 1;
				end
				if (got.press_pa !== exp_r.press_pa) begin
					$error("press_pa expected %0d got %0d", exp_r.press_pa, got.press_pa);
					failed = 1;
				end
				if (got.hum_q10 !== exp_r.hum_q10) begin
					$error("hum_q10 expected %0d got %0d", exp_r.hum_q10, got.hum_q10);
					failed = 1;
				end
			end
		end
	end

	// watchdog on cycles with no beat and no register write
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// valid is left high after acceptance; the next call or drain_results moves it
	task automatic send_reading(logic [19:0] t, logic [19:0] p, logic [15:0] h);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {h, p, t};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(compensate({h, p, t}));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_coeffs(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
			logic [15:0] p9, logic [39:0] hb, logic [31:0] hw);
		logic [2:0]  idx [8];
		logic [63:0] val [8];
		idx = '{REG_TEMP, REG_PLOW, REG_PHIGH, REG_PNINE, REG_HBYTES, REG_HWIDE,
			REG_SPARE_A, REG_SPARE_B};
		val = '{{16'd0, t}, pl, ph, {48'd0, p9}, {24'd0, hb}, {32'd0, hw},
			{$urandom, $urandom}, {$urandom, $urandom}};
		drain_results();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		coef_t  = t;
		coef_pl = pl;
		coef_ph = ph;
		coef_p9 = p9;
		coef_hb = hb;
		coef_hw = hw;
	endtask

	// datasheet-like trim set so results land in the physical range
	task automatic write_typical_coeffs(bit jitter);
		logic [15:0] j;
		j = jitter ? 16'($urandom_range(0, 63)) - 16'd32 : 16'd0;
		write_coeffs({16'hFC18 + j, 16'd26435 + j, 16'd27504 + j},
			{16'd2855, 16'd3024 + j, 16'hD643 + j, 16'd36477 + j},
			{16'hC6F8 + j, 16'd15500 + j, 16'hFFF9, 16'd140 + j},
			16'd6000 + j,
			{8'd30, 8'd0, 16'd362 + j, 8'd75},
			{16'd50, 16'd313 + j});
	endtask

	task automatic send_random_readings(int n);
		logic [19:0] t, p;
		logic [15:0] h;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					t = 20'd480000 + 20'($urandom_range(80000));
					p = 20'd250000 + 20'($urandom_range(300000));
					h = 16'd20000 + 16'($urandom_range(25000));
				end
				4: begin
					t = $urandom_range(1) ? SKIP_TP : 20'($urandom);
					p = $urandom_range(1) ? SKIP_TP : 20'($urandom);
					h = $urandom_range(1) ? SKIP_H : 16'($urandom);
				end
				default: begin
					t = 20'($urandom);
					p = 20'($urandom);
					h = 16'($urandom);
				end
			endcase
			send_reading(t, p, h);
		end
	endtask

	task automatic test_reset_coeffs();
		// all coefficients zero: pressure divisor is zero
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(SKIP_TP, 20'd0, 16'd0);
	endtask

	task automatic test_directed();
		write_typical_coeffs(0);
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'd540000, 20'd400000, 16'd45000);
		// skipped temperature: the rest uses the previous fine temperature
		send_reading(SKIP_TP, 20'd415148, 16'd30000);
		send_reading(20'd519888, SKIP_TP, SKIP_H);
		send_reading(SKIP_TP, SKIP_TP, SKIP_H);
		send_reading(20'd519888, 20'd415148, 16'd0);
		send_reading(20'd519888, 20'd415148, 16'd65000);
		send_reading(20'h7FFFF, 20'h80001, 16'h7FFF);
		send_reading(20'd519888, 20'd415148, 16'h8001);
	endtask

	task automatic test_extreme_coeffs();
		write_coeffs('1, '1, '1, '1, '1, '1);
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
		send_reading(20'd0, 20'hFFFFF, 16'd0);
		write_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{4{16'h8000}}, 16'h8000, {8'h80, 8'hFF, 16'h8000, 8'hFF},
			{16'h8000, 16'h8000});
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		write_coeffs({16'h7FFF, 16'h7FFF, 16'd0}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0},
			{4{16'h7FFF}}, 16'h7FFF, {8'h7F, 8'd0, 16'h7FFF, 8'd0},
			{16'h7FFF, 16'h7FFF});
		send_reading(20'd519888, 20'd415148, 16'd30000);
		send_reading(20'd0, 20'd0, 16'd0);
	endtask

	task automatic test_random_phases();
		int idle_mix [4];
		int stall_mix [4];
		idle_mix  = '{0, 68, 0, 29};
		stall_mix = '{0, 0, 68, 29};
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct  = idle_mix[ph % 4];
			recv_stall_pct = stall_mix[ph % 4];
			if (ph % 3 == 2)
				write_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom}, 16'($urandom), 40'({$urandom, $urandom}),
					$urandom);
			else
				write_typical_coeffs(1);
			send_random_readings(N_RANDOM / 16);
			// hold off until every result is back, then carry on with the same set
			drain_results();
			send_random_readings(N_RANDOM / 16);
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		coef_t  = '0;
		coef_pl = '0;
		coef_ph = '0;
		coef_p9 = '0;
		coef_hb = '0;
		coef_hw = '0;
		fine_t  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_coeffs();
		test_directed();
		test_extreme_coeffs();
		test_random_phases();
		drain_results();
		repeat (80) @(posedge clk);
		if (!failed)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
hdl/esc_pkg.sv
hdl/esc_div.sv
hdl/esc_datapath.sv
hdl/esc_ctrl.sv
hdl/env_sensor_compensation.sv
verif/env_sensor_compensation_tb.sv
